@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: label");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

@@ sv/apd_pkg.sv @@
// shared types, codes and name tables of the attribute list decoder
`default_nettype none

package apd_pkg;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_PAIR   = 3'd1;
    localparam logic [2:0] ST_UNKNOWN    = 3'd2;
    localparam logic [2:0] ST_DUPLICATE  = 3'd3;
    localparam logic [2:0] ST_BAD_ESCAPE = 3'd4;

    localparam logic [7:0] CHAR_SEMI    = 8'h3B;
    localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;

    localparam logic [2:0] NAME_LEN = 3'd6;
    localparam logic [2:0] NAME_SAT = 3'd7;

    localparam logic ATTR_KEY_ID = 1'b0;
    localparam logic ATTR_REGION = 1'b1;

    typedef struct packed {
        logic       value_start;
        logic       attribute;
        logic       byte_valid;
        logic [7:0] value_byte;
        logic       done_res;
        logic [2:0] status;
        logic       key_id_seen;
        logic       region_seen;
    } res_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_digit(input logic [7:0] b);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
            h.val = 4'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66)
            h.val = 4'(b - 8'h57);
        else if (b >= 8'h41 && b <= 8'h46)
            h.val = 4'(b - 8'h37);
        else
            h.ok = 1'b0;
        return h;
    endfunction

    // expected character of "key-id" at a name position
    function automatic logic [7:0] key_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h6B;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h79;
            3'd3:    c = 8'h2D;
            3'd4:    c = 8'h69;
            3'd5:    c = 8'h64;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // expected character of "region" at a name position
    function automatic logic [7:0] region_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h72;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h67;
            3'd3:    c = 8'h69;
            3'd4:    c = 8'h6F;
            3'd5:    c = 8'h6E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ sv/apd_core.sv @@
// parse state and result register: one path byte per step
`default_nettype none

module apd_core
    import apd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] byte_in,
    input  wire logic       last_in,
    output res_t            res
);

    typedef enum logic [2:0] {
        PH_NAME   = 3'd0,
        PH_VALUE  = 3'd1,
        PH_ESC_HI = 3'd2,
        PH_ESC_LO = 3'd3,
        PH_SKIP   = 3'd4
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [2:0] name_pos_reg, name_pos_next;
    logic       match_key_reg, match_key_next;
    logic       match_region_reg, match_region_next;
    logic [3:0] high_nib_reg, high_nib_next;
    logic       cur_attr_reg, cur_attr_next;
    logic       key_seen_reg, key_seen_next;
    logic       region_seen_reg, region_seen_next;
    logic [2:0] err_reg, err_next;
    res_t       res_reg, res_next;

    hex_t       hex;
    logic       attr_sel;
    logic       attr_known;
    logic [7:0] esc_val;

    assign hex     = hex_digit(byte_in);
    assign esc_val = {high_nib_reg, hex.val};

    always_comb
    begin
        phase_next        = phase_reg;
        name_pos_next     = name_pos_reg;
        match_key_next    = match_key_reg;
        match_region_next = match_region_reg;
        high_nib_next     = high_nib_reg;
        cur_attr_next     = cur_attr_reg;
        key_seen_next     = key_seen_reg;
        region_seen_next  = region_seen_reg;
        err_next          = err_reg;
        res_next          = '0;
        attr_known        = 1'b0;
        attr_sel          = ATTR_KEY_ID;

        if (err_reg == ST_OK)
        begin
            unique case (phase_reg)
                PH_NAME:
                begin
                    if (byte_in == CHAR_SEMI)
                    begin
                        if (name_pos_reg != 3'd0)
                        begin
                            err_next   = ST_NOT_PAIR;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            match_key_next    = 1'b1;
                            match_region_next = 1'b1;
                        end
                    end
                    else if (byte_in == CHAR_EQUAL)
                    begin
                        if (name_pos_reg == NAME_LEN && match_key_reg)
                        begin
                            attr_known = 1'b1;
                            attr_sel   = ATTR_KEY_ID;
                        end
                        else if (name_pos_reg == NAME_LEN && match_region_reg)
                        begin
                            attr_known = 1'b1;
                            attr_sel   = ATTR_REGION;
                        end

                        if (!attr_known)
                        begin
                            err_next   = ST_UNKNOWN;
                            phase_next = PH_SKIP;
                        end
                        else if ((attr_sel == ATTR_KEY_ID && key_seen_reg) ||
                                 (attr_sel == ATTR_REGION && region_seen_reg))
                        begin
                            err_next   = ST_DUPLICATE;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            if (attr_sel == ATTR_KEY_ID)
                                key_seen_next = 1'b1;
                            else
                                region_seen_next = 1'b1;
                            cur_attr_next        = attr_sel;
                            phase_next           = PH_VALUE;
                            res_next.value_start = 1'b1;
                            res_next.attribute   = attr_sel;
                        end
                    end
                    else
                    begin
                        if (name_pos_reg < NAME_LEN)
                        begin
                            if (byte_in != key_char(name_pos_reg))
                                match_key_next = 1'b0;
                            if (byte_in != region_char(name_pos_reg))
                                match_region_next = 1'b0;
                        end
                        else
                        begin
                            match_key_next    = 1'b0;
                            match_region_next = 1'b0;
                        end
                        if (name_pos_reg < NAME_SAT)
                            name_pos_next = name_pos_reg + 3'd1;
                    end
                end
                PH_VALUE:
                begin
                    if (byte_in == CHAR_SEMI)
                    begin
                        phase_next        = PH_NAME;
                        name_pos_next     = 3'd0;
                        match_key_next    = 1'b1;
                        match_region_next = 1'b1;
                    end
                    else if (byte_in == CHAR_PERCENT)
                        phase_next = PH_ESC_HI;
                    else if (byte_in == 8'h00)
                    begin
                        err_next   = ST_BAD_ESCAPE;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        res_next.byte_valid = 1'b1;
                        res_next.value_byte = byte_in;
                        res_next.attribute  = cur_attr_reg;
                    end
                end
                PH_ESC_HI:
                begin
                    if (!hex.ok)
                    begin
                        err_next   = ST_BAD_ESCAPE;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        high_nib_next = hex.val;
                        phase_next    = PH_ESC_LO;
                    end
                end
                PH_ESC_LO:
                begin
                    // a %00 escape is rejected like a bad digit
                    if (!hex.ok || esc_val == 8'h00)
                    begin
                        err_next   = ST_BAD_ESCAPE;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        res_next.byte_valid = 1'b1;
                        res_next.value_byte = esc_val;
                        res_next.attribute  = cur_attr_reg;
                        phase_next          = PH_VALUE;
                    end
                end
                default:
                begin
                end
            endcase

            // end of path inside a name or an escape
            if (last_in && err_next == ST_OK)
            begin
                if (phase_next == PH_NAME && name_pos_next != 3'd0)
                    err_next = ST_NOT_PAIR;
                else if (phase_next == PH_ESC_HI || phase_next == PH_ESC_LO)
                    err_next = ST_BAD_ESCAPE;
            end
        end

        if (last_in)
        begin
            res_next.done_res    = 1'b1;
            res_next.status      = err_next;
            res_next.key_id_seen = key_seen_next;
            res_next.region_seen = region_seen_next;

            phase_next        = PH_NAME;
            name_pos_next     = 3'd0;
            match_key_next    = 1'b1;
            match_region_next = 1'b1;
            high_nib_next     = 4'd0;
            cur_attr_next     = ATTR_KEY_ID;
            key_seen_next     = 1'b0;
            region_seen_next  = 1'b0;
            err_next          = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_NAME;
            name_pos_reg     <= 3'd0;
            match_key_reg    <= 1'b1;
            match_region_reg <= 1'b1;
            high_nib_reg     <= 4'd0;
            cur_attr_reg     <= ATTR_KEY_ID;
            key_seen_reg     <= 1'b0;
            region_seen_reg  <= 1'b0;
            err_reg          <= ST_OK;
            res_reg          <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            name_pos_reg     <= name_pos_next;
            match_key_reg    <= match_key_next;
            match_region_reg <= match_region_next;
            high_nib_reg     <= high_nib_next;
            cur_attr_reg     <= cur_attr_next;
            key_seen_reg     <= key_seen_next;
            region_seen_reg  <= region_seen_next;
            err_reg          <= err_next;
            res_reg          <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

@@ sv/attribute_list_percent_decoder.sv @@
// Attribute list percent decoder: takes one byte of a ';'-separated name=value
// list per beat (last_byte marks the end of the path) and returns one result
// beat per input beat. Only key-id and region are accepted, each once; values
// are percent-decoded and given byte by byte with value_start on the '='. The
// first error sticks, and on the last byte done_res carries status and the seen
// flags; bytes already given for a failed path are to be discarded. Throughput
// is one byte per cycle while out_ready is held high; a result appears on the
// outputs at the edge that moves its byte from the input register through the
// single parse step into the result register. A waiting result lets the next
// byte enter an empty input register, but a held byte then waits for out_ready.
`default_nettype none

module attribute_list_percent_decoder
    import apd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] path_byte,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            value_start,
    output logic            attribute,
    output logic            byte_valid,
    output logic [7:0]      value_byte,
    output logic            done_res,
    output logic [2:0]      status,
    output logic            key_id_seen,
    output logic            region_seen
);

    logic       in_vld_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       out_vld_reg;
    logic       advance;
    res_t       res;

    // move the held byte through the parser when the result slot frees up
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= path_byte;
            last_reg <= last_byte;
        end
    end

    apd_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (byte_reg),
        .last_in (last_reg),
        .res     (res)
    );

    assign out_valid   = out_vld_reg;
    assign value_start = res.value_start;
    assign attribute   = res.attribute;
    assign byte_valid  = res.byte_valid;
    assign value_byte  = res.value_byte;
    assign done_res    = res.done_res;
    assign status      = res.status;
    assign key_id_seen = res.key_id_seen;
    assign region_seen = res.region_seen;

endmodule

`default_nettype wire

@@ sv/apd_checker.sv @@
// port-level checks of the attribute list decoder and their bind
`default_nettype none

`include "assert_macros.svh"

module apd_checker
    import apd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       value_start,
    input wire logic       attribute,
    input wire logic       byte_valid,
    input wire logic [7:0] value_byte,
    input wire logic       done_res,
    input wire logic [2:0] status,
    input wire logic       key_id_seen,
    input wire logic       region_seen
);

    // a stalled result beat keeps its payload
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value_byte) && $stable(status))

    // decoded bytes are never zero
    `ASSERT_IMPLIES(a_byte_nonzero, out_valid && byte_valid, value_byte != 8'h00)

    // status and seen flags only appear on the last beat of a path
    `ASSERT_IMPLIES(a_done_fields, out_valid && !done_res, status == ST_OK && !key_id_seen && !region_seen)

    // an opening '=' carries no byte, and at path end its attribute is marked seen
    `ASSERT_IMPLIES(a_start_seen, out_valid && value_start, !byte_valid && (!done_res || (attribute ? region_seen : key_id_seen)))

endmodule

bind attribute_list_percent_decoder apd_checker u_apd_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value_start (value_start),
    .attribute   (attribute),
    .byte_valid  (byte_valid),
    .value_byte  (value_byte),
    .done_res    (done_res),
    .status      (status),
    .key_id_seen (key_id_seen),
    .region_seen (region_seen)
);

`default_nettype wire
